// ----- sv/eida_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eida_pkg: shared types and constants of the entity id allocator
// widths, operation codes, status codes and the controller/datapath bundles
// ----------------------------------------------------------------------------
package eida_pkg;

	localparam int ENTITY_CAPACITY = 4096;
	localparam int ID_W            = $clog2(ENTITY_CAPACITY);
	localparam int CNT_W           = ID_W + 1;
	localparam int SIG_W           = 32;
	localparam int IN_ID_W         = 16;
	localparam int KIND_W          = 3;

	typedef logic [ID_W-1:0]    id_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [SIG_W-1:0]   sig_t;
	typedef logic [IN_ID_W-1:0] ent_id_t;
	typedef logic [KIND_W-1:0]  kind_t;

	localparam kind_t KIND_CREATE  = kind_t'(0);
	localparam kind_t KIND_DESTROY = kind_t'(1);
	localparam kind_t KIND_SET     = kind_t'(2);
	localparam kind_t KIND_GET     = kind_t'(3);
	localparam kind_t KIND_ALIVE   = kind_t'(4);

	// map entry meaning "not live"
	localparam cnt_t    NOT_LIVE = cnt_t'(ENTITY_CAPACITY);
	localparam cnt_t    CAP_CNT  = cnt_t'(ENTITY_CAPACITY);
	localparam id_t     ID_LAST  = id_t'(ENTITY_CAPACITY - 1);
	localparam ent_id_t ID_LIMIT = ent_id_t'(ENTITY_CAPACITY);

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_FULL,
		STATUS_INVALID,
		STATUS_DEAD
	} status_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_CREATE,
		RES_GET,
		RES_ALIVE
	} res_sel_t;

	typedef struct packed {
		logic     accept;
		logic     clr_step;
		logic     create_wr;
		logic     destroy_wr1;
		logic     destroy_wr2;
		logic     set_wr;
		logic     finish;
		res_sel_t res_sel;
		status_t  res_status;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  full;
		logic  hole_invalid;
		logic  clr_last;
	} stat_t;

endpackage
`default_nettype wire

// ----- sv/eida_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eida_ctrl: operation sequencer
// walks the clearing sweep after reset, then steps each operation through
// its memory read and write cycles and tells the datapath when to finish
// ----------------------------------------------------------------------------
module eida_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire eida_pkg::stat_t stat,
	output eida_pkg::cmd_t       cmd,
	output logic                 busy
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CREATE,
		S_DCHK,
		S_DFIN,
		S_READ
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd            = '0;
		cmd.res_sel    = eida_pkg::RES_NONE;
		cmd.res_status = eida_pkg::STATUS_OK;
		state_d        = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && !busy_q) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.kind) inside
					eida_pkg::KIND_CREATE: begin
						if (stat.full) begin
							cmd.finish     = 1'b1;
							cmd.res_status = eida_pkg::STATUS_FULL;
							state_d        = S_IDLE;
						end else begin
							state_d = S_CREATE;
						end
					end
					eida_pkg::KIND_DESTROY: begin
						if (!stat.in_range) begin
							cmd.finish     = 1'b1;
							cmd.res_status = eida_pkg::STATUS_INVALID;
							state_d        = S_IDLE;
						end else begin
							state_d = S_DCHK;
						end
					end
					eida_pkg::KIND_SET: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.in_range) begin
							cmd.set_wr = 1'b1;
						end else begin
							cmd.res_status = eida_pkg::STATUS_INVALID;
						end
					end
					eida_pkg::KIND_GET, eida_pkg::KIND_ALIVE: begin
						if (!stat.in_range) begin
							cmd.finish     = 1'b1;
							cmd.res_status = eida_pkg::STATUS_INVALID;
							state_d        = S_IDLE;
						end else begin
							state_d = S_READ;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_CREATE: begin
				cmd.create_wr = 1'b1;
				cmd.finish    = 1'b1;
				cmd.res_sel   = eida_pkg::RES_CREATE;
				state_d       = S_IDLE;
			end
			S_DCHK: begin
				if (stat.hole_invalid) begin
					cmd.finish     = 1'b1;
					cmd.res_status = eida_pkg::STATUS_DEAD;
					state_d        = S_IDLE;
				end else begin
					cmd.destroy_wr1 = 1'b1;
					state_d         = S_DFIN;
				end
			end
			S_DFIN: begin
				// index map entry of the destroyed id is cleared last, so a
				// destroy of the tail entry ends up not live
				cmd.destroy_wr2 = 1'b1;
				cmd.finish      = 1'b1;
				state_d         = S_IDLE;
			end
			S_READ: begin
				cmd.finish  = 1'b1;
				cmd.res_sel = (stat.kind == eida_pkg::KIND_GET) ?
					eida_pkg::RES_GET : eida_pkg::RES_ALIVE;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

endmodule
`default_nettype wire

// ----- sv/eida_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eida_dp: allocator datapath
// free id fifo, dense live array, id to dense index map and signature store,
// their pointers and counters, and the result registers
// ----------------------------------------------------------------------------
module eida_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire eida_pkg::cmd_t    cmd,
	input  wire eida_pkg::kind_t   kind,
	input  wire eida_pkg::ent_id_t entity_id,
	input  wire eida_pkg::sig_t    new_signature,
	output eida_pkg::stat_t        stat,
	output logic                   done,
	output eida_pkg::status_t      status,
	output eida_pkg::id_t          allocated_id,
	output eida_pkg::sig_t         signature_out,
	output logic                   is_alive,
	output eida_pkg::cnt_t         live_count
);

	eida_pkg::id_t    fifo_mem  [eida_pkg::ENTITY_CAPACITY];
	eida_pkg::id_t    dense_mem [eida_pkg::ENTITY_CAPACITY];
	eida_pkg::cnt_t   map_mem   [eida_pkg::ENTITY_CAPACITY];
	eida_pkg::sig_t   sig_mem   [eida_pkg::ENTITY_CAPACITY];

	eida_pkg::id_t    fifo_rd_q;
	eida_pkg::id_t    dense_rd_q;
	eida_pkg::cnt_t   map_rd_q;
	eida_pkg::sig_t   sig_rd_q;

	eida_pkg::kind_t  kind_q;
	eida_pkg::ent_id_t id_q;
	eida_pkg::sig_t   sig_in_q;

	eida_pkg::id_t    head_q;
	eida_pkg::cnt_t   count_q;
	eida_pkg::cnt_t   live_q;
	eida_pkg::id_t    clr_q;

	eida_pkg::status_t status_q;
	eida_pkg::id_t    alloc_q;
	eida_pkg::sig_t   sig_out_q;
	logic             alive_q;
	logic             done_q;

	eida_pkg::id_t    id_a;
	eida_pkg::id_t    dense_ra;
	eida_pkg::id_t    push_a;

	logic             fifo_we;
	eida_pkg::id_t    fifo_wa;
	eida_pkg::id_t    fifo_wd;
	logic             dense_we;
	eida_pkg::id_t    dense_wa;
	eida_pkg::id_t    dense_wd;
	logic             map_we;
	eida_pkg::id_t    map_wa;
	eida_pkg::cnt_t   map_wd;
	logic             sig_we;
	eida_pkg::id_t    sig_wa;
	eida_pkg::sig_t   sig_wd;

	assign id_a     = id_q[eida_pkg::ID_W-1:0];
	assign dense_ra = eida_pkg::id_t'(live_q - eida_pkg::cnt_t'(1));
	// tail of the free fifo wraps with the capacity
	assign push_a   = eida_pkg::id_t'(eida_pkg::cnt_t'(head_q) + count_q);

	assign stat.kind         = kind_q;
	assign stat.in_range     = (id_q < eida_pkg::ID_LIMIT);
	assign stat.full         = (live_q >= eida_pkg::CAP_CNT) || (count_q == '0);
	assign stat.hole_invalid = (map_rd_q >= eida_pkg::NOT_LIVE) || (live_q == '0);
	assign stat.clr_last     = (clr_q == eida_pkg::ID_LAST);

	always_comb begin
		fifo_we  = 1'b0;
		fifo_wa  = push_a;
		fifo_wd  = id_a;
		dense_we = 1'b0;
		dense_wa = dense_rd_q;
		dense_wd = dense_rd_q;
		map_we   = 1'b0;
		map_wa   = id_a;
		map_wd   = eida_pkg::NOT_LIVE;
		sig_we   = 1'b0;
		sig_wa   = id_a;
		sig_wd   = '0;
		if (cmd.clr_step) begin
			fifo_we = 1'b1;
			fifo_wa = clr_q;
			fifo_wd = clr_q;
			map_we  = 1'b1;
			map_wa  = clr_q;
			sig_we  = 1'b1;
			sig_wa  = clr_q;
		end
		if (cmd.create_wr) begin
			dense_we = 1'b1;
			dense_wa = eida_pkg::id_t'(live_q);
			dense_wd = fifo_rd_q;
			map_we   = 1'b1;
			map_wa   = fifo_rd_q;
			map_wd   = live_q;
		end
		if (cmd.destroy_wr1) begin
			// move the tail entry into the hole and return the id to the fifo
			dense_we = 1'b1;
			dense_wa = eida_pkg::id_t'(map_rd_q);
			dense_wd = dense_rd_q;
			map_we   = 1'b1;
			map_wa   = dense_rd_q;
			map_wd   = map_rd_q;
			sig_we   = 1'b1;
			fifo_we  = (count_q < eida_pkg::CAP_CNT);
		end
		if (cmd.destroy_wr2) begin
			map_we = 1'b1;
		end
		if (cmd.set_wr) begin
			sig_we = 1'b1;
			sig_wd = sig_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_wa] <= fifo_wd;
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (dense_we) begin
			dense_mem[dense_wa] <= dense_wd;
		end
		dense_rd_q <= dense_mem[dense_ra];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[id_a];
	end

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[sig_wa] <= sig_wd;
		end
		sig_rd_q <= sig_mem[id_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= eida_pkg::CAP_CNT;
			live_q  <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clr_step) begin
				clr_q <= clr_q + eida_pkg::id_t'(1);
			end
			if (cmd.create_wr) begin
				head_q  <= head_q + eida_pkg::id_t'(1);
				count_q <= count_q - eida_pkg::cnt_t'(1);
				live_q  <= live_q + eida_pkg::cnt_t'(1);
			end
			if (cmd.destroy_wr1 && (count_q < eida_pkg::CAP_CNT)) begin
				count_q <= count_q + eida_pkg::cnt_t'(1);
			end
			if (cmd.destroy_wr2) begin
				live_q <= live_q - eida_pkg::cnt_t'(1);
			end
		end
	end

	// beat payload and results
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= kind;
			id_q     <= entity_id;
			sig_in_q <= new_signature;
		end
		if (cmd.finish) begin
			status_q  <= cmd.res_status;
			alloc_q   <= (cmd.res_sel == eida_pkg::RES_CREATE) ? fifo_rd_q : '0;
			sig_out_q <= (cmd.res_sel == eida_pkg::RES_GET) ? sig_rd_q : '0;
			alive_q   <= (cmd.res_sel == eida_pkg::RES_ALIVE) &&
				(map_rd_q < eida_pkg::NOT_LIVE);
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign allocated_id  = alloc_q;
	assign signature_out = sig_out_q;
	assign is_alive      = alive_q;
	assign live_count    = live_q;

endmodule
`default_nettype wire

// ----- sv/entity_id_allocator_dense_set.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entity_id_allocator_dense_set: entity id allocator with free fifo and
// dense live set
//
// an operation beat is taken at a rising edge with start high and busy low:
// kind, entity_id and new_signature are sampled there. exactly one result
// beat follows, shown for one cycle with done high, and it must be taken
// then: the receiver cannot stall it. live_count gives the live total after
// the operation while done is high.
// each operation passes the execute state, then registered memory reads
// and writes: create adds a write state (none when full), destroy a check
// and a write state (only the check when not live), get and alive query a
// read state; set, out of range ids and unused kinds finish from execute.
// busy drops in the done cycle, so a new beat can be taken there.
// after reset a clearing sweep fills the free fifo in order and clears the
// index map and signature store; busy stays high throughout.
// ----------------------------------------------------------------------------
module entity_id_allocator_dense_set (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire eida_pkg::kind_t   kind,
	input  wire eida_pkg::ent_id_t entity_id,
	input  wire eida_pkg::sig_t    new_signature,
	output logic                   done,
	output eida_pkg::status_t      status,
	output eida_pkg::id_t          allocated_id,
	output eida_pkg::sig_t         signature_out,
	output logic                   is_alive,
	output eida_pkg::cnt_t         live_count
);

	eida_pkg::cmd_t  cmd;
	eida_pkg::stat_t stat;

	eida_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	eida_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.entity_id     (entity_id),
		.new_signature (new_signature),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.allocated_id  (allocated_id),
		.signature_out (signature_out),
		.is_alive      (is_alive),
		.live_count    (live_count)
	);

endmodule
`default_nettype wire

// ----- tb/tb_entity_id_allocator_dense_set.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_entity_id_allocator_dense_set: self-checking bench of the id allocator
// a scoreboard keeps its own free fifo, dense set, index map and signature
// store, works out the result of every accepted operation beat and checks
// each done beat against it. directed beats cover the special cases, then
// random beats follow. the sender idles at random between beats.
// ----------------------------------------------------------------------------
module tb_entity_id_allocator_dense_set;

	localparam int              CYCLE_LIMIT      = 100000;
	localparam int              RANDOM_BEATS     = 375;
	localparam eida_pkg::kind_t KIND_SPARE_FIRST =
		eida_pkg::KIND_ALIVE + eida_pkg::kind_t'(1);
	localparam eida_pkg::kind_t KIND_SPARE_LAST  = '1;

	typedef struct {
		eida_pkg::status_t status;
		eida_pkg::id_t     alloc;
		eida_pkg::sig_t    sig;
		logic              alive;
		eida_pkg::cnt_t    count;
	} reply_t;

	class id_store_sb;
		eida_pkg::id_t  free_ids [eida_pkg::ENTITY_CAPACITY];
		eida_pkg::id_t  dense    [eida_pkg::ENTITY_CAPACITY];
		int             slot     [eida_pkg::ENTITY_CAPACITY];
		eida_pkg::sig_t sigs     [eida_pkg::ENTITY_CAPACITY];
		int             head;
		int             free_count;
		int             live;
		int             faults;
		reply_t         replies_due [$];

		function new();
			for (int i = 0; i < eida_pkg::ENTITY_CAPACITY; i++) begin
				free_ids[i] = eida_pkg::id_t'(i);
				dense[i]    = '0;
				slot[i]     = eida_pkg::ENTITY_CAPACITY;
				sigs[i]     = '0;
			end
			head       = 0;
			free_count = eida_pkg::ENTITY_CAPACITY;
			live       = 0;
			faults     = 0;
		endfunction

		// apply one accepted operation and queue the reply it must give
		function void note_op(eida_pkg::kind_t k, eida_pkg::ent_id_t eid, eida_pkg::sig_t s);
			reply_t        r;
			bit            in_range;
			int            idx;
			int            hole;
			int            tail;
			eida_pkg::id_t last_id;
			eida_pkg::id_t nid;
			r.status = eida_pkg::STATUS_OK;
			r.alloc  = '0;
			r.sig    = '0;
			r.alive  = 1'b0;
			in_range = eid < eida_pkg::ID_LIMIT;
			idx      = in_range ? int'(eid) : 0;
			case (k)
				eida_pkg::KIND_CREATE: begin
					if (live >= eida_pkg::ENTITY_CAPACITY || free_count == 0) begin
						r.status = eida_pkg::STATUS_FULL;
					end else begin
						nid         = free_ids[head];
						head        = (head + 1) % eida_pkg::ENTITY_CAPACITY;
						free_count--;
						dense[live] = nid;
						slot[nid]   = live;
						live++;
						r.alloc     = nid;
					end
				end
				eida_pkg::KIND_DESTROY: begin
					if (!in_range) begin
						r.status = eida_pkg::STATUS_INVALID;
					end else if (slot[idx] >= eida_pkg::ENTITY_CAPACITY || live == 0) begin
						r.status = eida_pkg::STATUS_DEAD;
					end else begin
						// swap the last live id into the hole
						hole          = slot[idx];
						last_id       = dense[live-1];
						dense[hole]   = last_id;
						slot[last_id] = hole;
						slot[idx]     = eida_pkg::ENTITY_CAPACITY;
						sigs[idx]     = '0;
						if (free_count < eida_pkg::ENTITY_CAPACITY) begin
							tail           = (head + free_count) % eida_pkg::ENTITY_CAPACITY;
							free_ids[tail] = eida_pkg::id_t'(idx);
							free_count++;
						end
						live--;
					end
				end
				eida_pkg::KIND_SET: begin
					if (!in_range) r.status = eida_pkg::STATUS_INVALID;
					else sigs[idx] = s;
				end
				eida_pkg::KIND_GET: begin
					if (!in_range) r.status = eida_pkg::STATUS_INVALID;
					else r.sig = sigs[idx];
				end
				eida_pkg::KIND_ALIVE: begin
					if (!in_range) r.status = eida_pkg::STATUS_INVALID;
					else r.alive = slot[idx] < eida_pkg::ENTITY_CAPACITY;
				end
				default: begin
				end
			endcase
			r.count = eida_pkg::cnt_t'(live);
			replies_due.push_back(r);
		endfunction

		function void check_reply(eida_pkg::status_t st, eida_pkg::id_t aid,
				eida_pkg::sig_t sg, logic al, eida_pkg::cnt_t lc);
			reply_t e;
			if (replies_due.size() == 0) begin
				$error("result beat with nothing expected");
				faults++;
				return;
			end
			e = replies_due.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				faults++;
			end
			if (aid !== e.alloc) begin
				$error("allocated_id: expected %0d, got %0d", e.alloc, aid);
				faults++;
			end
			if (sg !== e.sig) begin
				$error("signature_out: expected %h, got %h", e.sig, sg);
				faults++;
			end
			if (al !== e.alive) begin
				$error("is_alive: expected %0b, got %0b", e.alive, al);
				faults++;
			end
			if (lc !== e.count) begin
				$error("live_count: expected %0d, got %0d", e.count, lc);
				faults++;
			end
		endfunction

		function int waiting();
			return replies_due.size();
		endfunction

		function eida_pkg::ent_id_t any_live();
			if (live == 0)
				return eida_pkg::ent_id_t'($urandom_range(0, eida_pkg::ENTITY_CAPACITY - 1));
			return eida_pkg::ent_id_t'(dense[$urandom_range(0, live - 1)]);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	eida_pkg::kind_t   kind;
	eida_pkg::ent_id_t entity_id;
	eida_pkg::sig_t    new_signature;
	logic              done;
	eida_pkg::status_t status;
	eida_pkg::id_t     allocated_id;
	eida_pkg::sig_t    signature_out;
	logic              is_alive;
	eida_pkg::cnt_t    live_count;

	id_store_sb sb;
	int         cycles     = 0;
	int         burst_left = 0;

	entity_id_allocator_dense_set DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.entity_id    (entity_id),
		.new_signature(new_signature),
		.done         (done),
		.status       (status),
		.allocated_id (allocated_id),
		.signature_out(signature_out),
		.is_alive     (is_alive),
		.live_count   (live_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL entity_id_allocator_dense_set");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply(status, allocated_id, signature_out, is_alive, live_count);
	end

	// idle cycles before a beat, with stretches of back-to-back beats
	function automatic int pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	task automatic issue(eida_pkg::kind_t k, eida_pkg::ent_id_t eid, eida_pkg::sig_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		kind          <= k;
		entity_id     <= eid;
		new_signature <= s;
		do @(posedge clk); while (busy);
		sb.note_op(k, eid, s);
	endtask

	function automatic eida_pkg::ent_id_t pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return sb.any_live();
		if (r < 85)
			return eida_pkg::ent_id_t'($urandom_range(0, eida_pkg::ENTITY_CAPACITY - 1));
		if (r < 95)
			return eida_pkg::ent_id_t'($urandom_range(eida_pkg::ENTITY_CAPACITY, 65535));
		return eida_pkg::ent_id_t'($urandom);
	endfunction

	function automatic eida_pkg::sig_t pick_sig();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return eida_pkg::sig_t'($urandom);
	endfunction

	task automatic run_random(int beats);
		int              r;
		eida_pkg::kind_t k;
		for (int n = 0; n < beats; n++) begin
			r = $urandom_range(0, 99);
			if (r < 25) k = eida_pkg::KIND_CREATE;
			else if (r < 45) k = eida_pkg::KIND_DESTROY;
			else if (r < 60) k = eida_pkg::KIND_SET;
			else if (r < 75) k = eida_pkg::KIND_GET;
			else if (r < 90) k = eida_pkg::KIND_ALIVE;
			else k = eida_pkg::kind_t'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			issue(k, pick_id(), pick_sig());
		end
	endtask

	initial begin
		sb            = new();
		arst_n        <= 1'b0;
		start         <= 1'b0;
		kind          <= eida_pkg::KIND_CREATE;
		entity_id     <= '0;
		new_signature <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, not-live ids, create order, swap removal, bad ids
		issue(eida_pkg::KIND_ALIVE, eida_pkg::ent_id_t'(0), '0);
		issue(eida_pkg::KIND_GET, eida_pkg::ent_id_t'(eida_pkg::ID_LAST), '0);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ent_id_t'(5), '0);
		issue(eida_pkg::KIND_SET, eida_pkg::ent_id_t'(7), eida_pkg::sig_t'(32'hA5A5_5A5A));
		issue(eida_pkg::KIND_GET, eida_pkg::ent_id_t'(7), '0);
		issue(eida_pkg::KIND_CREATE, '0, '0);
		issue(eida_pkg::KIND_CREATE, '0, '0);
		issue(eida_pkg::KIND_CREATE, '0, '0);
		issue(eida_pkg::KIND_ALIVE, eida_pkg::ent_id_t'(1), '0);
		issue(eida_pkg::KIND_SET, eida_pkg::ent_id_t'(1), '1);
		issue(eida_pkg::KIND_GET, eida_pkg::ent_id_t'(1), '0);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ent_id_t'(0), '0);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ent_id_t'(0), '0);
		issue(eida_pkg::KIND_ALIVE, eida_pkg::ent_id_t'(0), '0);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ID_LIMIT, '0);
		issue(eida_pkg::KIND_SET, '1, '1);
		issue(eida_pkg::KIND_GET, eida_pkg::ID_LIMIT, '0);
		issue(eida_pkg::KIND_ALIVE, '1, '0);
		for (eida_pkg::kind_t k = KIND_SPARE_FIRST; k != eida_pkg::KIND_CREATE; k++)
			issue(k, '1, '1);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ent_id_t'(2), '0);
		issue(eida_pkg::KIND_DESTROY, eida_pkg::ent_id_t'(1), '0);
		issue(eida_pkg::KIND_GET, eida_pkg::ent_id_t'(1), '0);
		issue(eida_pkg::KIND_CREATE, '0, '0);

		run_random(RANDOM_BEATS);

		start <= 1'b0;
		while (sb.waiting() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.faults == 0)
			$display("PASS entity_id_allocator_dense_set");
		else
			$display("FAIL entity_id_allocator_dense_set");
		$finish;
	end

endmodule
`default_nettype wire
